### rtl/oigm_pkg.sv
// Shared constants for the obstacle inflation grid map core.
package oigm_pkg;

  // register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_IMG_WIDTH   = 3'd0;
  localparam logic [2:0] REG_IMG_HEIGHT  = 3'd1;
  localparam logic [2:0] REG_RADIUS_ROWS = 3'd2;
  localparam logic [2:0] REG_RADIUS_COLS = 3'd3;
  localparam logic [2:0] REG_CELL_STEP   = 3'd4;

  // request kinds carried in tuser
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam int unsigned SIZE_W   = 10;
  localparam int unsigned RADIUS_W = 6;
  localparam int unsigned STEP_W   = 7;
  localparam int unsigned GRID_W   = 9;
  localparam int unsigned PROD_W   = GRID_W + STEP_W;

  localparam logic [SIZE_W-1:0]   RST_IMG_WIDTH  = 10'd512;
  localparam logic [SIZE_W-1:0]   RST_IMG_HEIGHT = 10'd512;
  localparam logic [RADIUS_W-1:0] RST_RADIUS     = 6'd4;
  localparam logic [STEP_W-1:0]   RST_CELL_STEP  = 7'd1;

  localparam logic [7:0] PIX_FULL = 8'd255;

  // map write request from the load path
  typedef struct packed {
    logic en;
    logic obst;
  } map_wr_ctl_t;

endpackage

### rtl/obstacle_inflation_grid_map_core.sv
// Obstacle inflation grid map core: pixel load, grid cell walkability query.
// Load: one transaction per cycle while idle, one map bit written per transaction.
// Query: states calc, check, scan (one map row read per cycle), drain, done;
//   check skips to done with nothing to scan; done holds on an output stall.
// Reset: control and load address cleared, registers to defaults; the map is
//   undefined until loaded, no clearing pass.
module obstacle_inflation_grid_map_core #(
  parameter int unsigned MAX_WIDTH  = 512,
  parameter int unsigned MAX_HEIGHT = 512,
  parameter int unsigned MAX_RADIUS = 63
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: red[7:0], green[15:8], blue[23:16], grid_row[32:24], grid_col[41:33]
  input  logic [47:0] s_axis_tdata,
  // tuser: req_type[0]
  input  logic        s_axis_tuser,
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: cell_row[8:0], cell_col[17:9], in_bounds[18], walkable[19]
  output logic [23:0] m_axis_tdata
);
  import oigm_pkg::*;

  localparam int unsigned CW  = $clog2(MAX_WIDTH);
  localparam int unsigned RW  = $clog2(MAX_HEIGHT);
  localparam int unsigned EWW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned EWH = $clog2(MAX_HEIGHT + 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_CALC, ST_CHECK, ST_SCAN, ST_DRAIN, ST_DONE
  } state_e;

  // configuration registers
  logic [SIZE_W-1:0]   img_width_q, img_height_q;
  logic [RADIUS_W-1:0] radius_rows_q, radius_cols_q;
  logic [STEP_W-1:0]   cell_step_q;

  logic cfg_wr;
  assign cfg_wr = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_width_q   <= RST_IMG_WIDTH;
      img_height_q  <= RST_IMG_HEIGHT;
      radius_rows_q <= RST_RADIUS;
      radius_cols_q <= RST_RADIUS;
      cell_step_q   <= RST_CELL_STEP;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_IMG_WIDTH:   img_width_q   <= pwdata[SIZE_W-1:0];
        REG_IMG_HEIGHT:  img_height_q  <= pwdata[SIZE_W-1:0];
        REG_RADIUS_ROWS: radius_rows_q <= pwdata[RADIUS_W-1:0];
        REG_RADIUS_COLS: radius_cols_q <= pwdata[RADIUS_W-1:0];
        REG_CELL_STEP:   cell_step_q   <= pwdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_IMG_WIDTH:   prdata = 32'(img_width_q);
      REG_IMG_HEIGHT:  prdata = 32'(img_height_q);
      REG_RADIUS_ROWS: prdata = 32'(radius_rows_q);
      REG_RADIUS_COLS: prdata = 32'(radius_cols_q);
      REG_CELL_STEP:   prdata = 32'(cell_step_q);
      default:         prdata = 32'd0;
    endcase
  end

  // effective sizes after clamping
  logic [EWW-1:0]      w_eff;
  logic [EWH-1:0]      h_eff;
  logic [STEP_W-1:0]   s_eff;
  logic [RADIUS_W-1:0] rr_eff, rc_eff;

  always_comb begin
    if (img_width_q == '0)                   w_eff = EWW'(1);
    else if (32'(img_width_q) > MAX_WIDTH)   w_eff = EWW'(MAX_WIDTH);
    else                                     w_eff = EWW'(img_width_q);
    if (img_height_q == '0)                  h_eff = EWH'(1);
    else if (32'(img_height_q) > MAX_HEIGHT) h_eff = EWH'(MAX_HEIGHT);
    else                                     h_eff = EWH'(img_height_q);
    s_eff  = (cell_step_q == '0) ? STEP_W'(1) : cell_step_q;
    rr_eff = (32'(radius_rows_q) > MAX_RADIUS) ? RADIUS_W'(MAX_RADIUS) : radius_rows_q;
    rc_eff = (32'(radius_cols_q) > MAX_RADIUS) ? RADIUS_W'(MAX_RADIUS) : radius_cols_q;
  end

  // input fields
  logic [7:0]        in_red, in_green, in_blue;
  logic [GRID_W-1:0] in_grid_row, in_grid_col;
  assign in_red      = s_axis_tdata[7:0];
  assign in_green    = s_axis_tdata[15:8];
  assign in_blue     = s_axis_tdata[23:16];
  assign in_grid_row = s_axis_tdata[32:24];
  assign in_grid_col = s_axis_tdata[41:33];

  state_e state_q;
  logic   in_xact;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xact       = s_axis_tvalid & s_axis_tready;

  // load address
  logic [CW-1:0] load_col_q;
  logic [RW-1:0] load_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_col_q <= '0;
      load_row_q <= '0;
    end else if (in_xact && s_axis_tuser == REQ_LOAD) begin
      if ((32'(load_col_q) + 32'd1) >= 32'(w_eff)) begin
        load_col_q <= '0;
        load_row_q <= ((32'(load_row_q) + 32'd1) >= 32'(h_eff)) ? '0 : load_row_q + 1'b1;
      end else begin
        load_col_q <= load_col_q + 1'b1;
      end
    end
  end

  map_wr_ctl_t wr_ctl;
  assign wr_ctl.en   = in_xact && (s_axis_tuser == REQ_LOAD);
  assign wr_ctl.obst = !((in_red == PIX_FULL) && (in_green == PIX_FULL) &&
                         (in_blue == PIX_FULL));

  // query datapath
  logic [GRID_W-1:0]    qrow_q, qcol_q;
  logic [PROD_W-1:0]    r0_q, c0_q;
  logic [EWH-1:0]       r_q, r1_q;
  logic [MAX_WIDTH-1:0] mask_q;
  logic                 inb_q, hit_q, rd_vld_q;
  logic                 rd_en;
  logic [MAX_WIDTH-1:0] rd_data;

  logic                 inb_d;
  logic [PROD_W:0]      r1_sum, c1_sum;
  logic [EWH-1:0]       r1_d;
  logic [EWW-1:0]       c0_d, c1_d;
  logic [MAX_WIDTH-1:0] mask_d;

  always_comb begin
    inb_d  = (32'(r0_q) < 32'(h_eff)) && (32'(c0_q) < 32'(w_eff));
    r1_sum = (PROD_W+1)'(r0_q) + (PROD_W+1)'(rr_eff);
    c1_sum = (PROD_W+1)'(c0_q) + (PROD_W+1)'(rc_eff);
    r1_d   = (32'(r1_sum) > 32'(h_eff)) ? h_eff : EWH'(r1_sum);
    c1_d   = (32'(c1_sum) > 32'(w_eff)) ? w_eff : EWW'(c1_sum);
    c0_d   = EWW'(c0_q);
    for (int i = 0; i < MAX_WIDTH; i++) begin
      mask_d[i] = (32'(i) >= 32'(c0_d)) && (32'(i) < 32'(c1_d));
    end
  end

  assign rd_en = (state_q == ST_SCAN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
      m_axis_tdata  <= '0;
      rd_vld_q      <= 1'b0;
      hit_q         <= 1'b0;
    end else begin
      rd_vld_q <= rd_en;
      if (rd_vld_q && |(rd_data & mask_q)) begin
        hit_q <= 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready && state_q != ST_DONE) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_xact && s_axis_tuser == REQ_QUERY) begin
            state_q <= ST_CALC;
          end
        end
        ST_CALC: state_q <= ST_CHECK;
        ST_CHECK: begin
          hit_q <= 1'b0;
          // out of grid or empty window: nothing to scan
          if (!inb_d || (32'(r0_q) >= 32'(r1_d)) || (32'(c0_d) >= 32'(c1_d))) begin
            state_q <= ST_DONE;
          end else begin
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (r_q + 1'b1 == r1_q) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: state_q <= ST_DONE;
        ST_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {4'd0, inb_q & ~hit_q, inb_q, qcol_q, qrow_q};
            state_q       <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xact) begin
      qrow_q <= in_grid_row;
      qcol_q <= in_grid_col;
    end
    if (state_q == ST_CALC) begin
      r0_q <= PROD_W'(qrow_q) * PROD_W'(s_eff);
      c0_q <= PROD_W'(qcol_q) * PROD_W'(s_eff);
    end
    if (state_q == ST_CHECK) begin
      inb_q  <= inb_d;
      r_q    <= EWH'(r0_q);
      r1_q   <= r1_d;
      mask_q <= mask_d;
    end
    if (state_q == ST_SCAN) begin
      r_q <= r_q + 1'b1;
    end
  end

  oigm_map #(
    .ROWS (MAX_HEIGHT),
    .COLS (MAX_WIDTH)
  ) u_map (
    .clk_i     (clk_i),
    .wr_ctl_i  (wr_ctl),
    .wr_row_i  (load_row_q),
    .wr_col_i  (load_col_q),
    .rd_en_i   (rd_en),
    .rd_row_i  (r_q[RW-1:0]),
    .rd_data_o (rd_data)
  );

endmodule

### rtl/oigm_map.sv
// Obstacle bit map: one row word per image row, bit write, registered row read.
module oigm_map #(
  parameter int unsigned ROWS = 512,
  parameter int unsigned COLS = 512
) (
  input  logic                      clk_i,
  input  oigm_pkg::map_wr_ctl_t     wr_ctl_i,
  input  logic [$clog2(ROWS)-1:0]   wr_row_i,
  input  logic [$clog2(COLS)-1:0]   wr_col_i,
  input  logic                      rd_en_i,
  input  logic [$clog2(ROWS)-1:0]   rd_row_i,
  output logic [COLS-1:0]           rd_data_o
);
  import oigm_pkg::*;

  logic [COLS-1:0] mem [ROWS];
  logic [COLS-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_ctl_i.en) begin
      mem[wr_row_i][wr_col_i] <= wr_ctl_i.obst;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_row_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### tb/tb_obstacle_inflation_grid_map_core.sv
// Testbench for the obstacle inflation grid map core: pixel loads, cell queries, APB setup.
module tb_obstacle_inflation_grid_map_core;
  import oigm_pkg::*;

  localparam int unsigned MAX_W       = 512;
  localparam int unsigned MAX_H       = 512;
  localparam int unsigned MAX_RAD     = 63;
  localparam int unsigned SETTLE      = 4;
  localparam int unsigned DRAIN       = 100;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned RAND_ITEMS  = 1250;

  typedef struct {
    bit          is_cfg;
    logic [2:0]  reg_idx;
    logic [31:0] value;
    logic        kind;
    logic [47:0] data;
  } req_item_t;

  typedef struct packed {
    logic [8:0] row;
    logic [8:0] col;
    logic       inb;
    logic       walk;
  } cell_answer_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b1;
  logic [4:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // red[7:0], green[15:8], blue[23:16], grid_row[32:24], grid_col[41:33]
  logic [47:0] s_axis_tdata  = '0;
  // req_type[0]
  logic        s_axis_tuser  = REQ_LOAD;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // cell_row[8:0], cell_col[17:9], in_bounds[18], walkable[19]
  logic [23:0] m_axis_tdata;

  obstacle_inflation_grid_map_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  req_item_t    req_q[$];
  cell_answer_t cell_answers_q[$];

  int unsigned mismatches   = 0;
  int unsigned results_seen = 0;
  int unsigned queries_sent = 0;
  int unsigned cycle_count  = 0;
  int unsigned n_loads      = 0;
  int unsigned n_queries    = 0;
  int unsigned n_inb        = 0;
  int unsigned n_walk       = 0;
  int unsigned n_cfg        = 0;

  // ---------------------------------------------------------------------------
  // Shared helpers

  function automatic int unsigned clamp_dim(int unsigned raw, int unsigned lim);
    if (raw == 0) return 1;
    if (raw > lim) return lim;
    return raw;
  endfunction

  // raster address advance; wrap tests use the size in force now
  function automatic void advance_addr(inout int unsigned row, inout int unsigned col,
                                       input int unsigned w, input int unsigned h);
    if (col + 1 >= w) begin
      col = 0;
      row = (row + 1 >= h) ? 0 : row + 1;
    end else begin
      col = col + 1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Occupancy predictor

  bit          map_bits [0:MAX_W*MAX_H-1];
  int unsigned ld_row    = 0;
  int unsigned ld_col    = 0;
  logic [9:0]  cfg_w     = RST_IMG_WIDTH;
  logic [9:0]  cfg_h     = RST_IMG_HEIGHT;
  logic [5:0]  cfg_rr    = RST_RADIUS;
  logic [5:0]  cfg_rc    = RST_RADIUS;
  logic [6:0]  cfg_step  = RST_CELL_STEP;

  function automatic void apply_reg(logic [2:0] idx, logic [31:0] val);
    case (idx)
      REG_IMG_WIDTH:   cfg_w    = val[9:0];
      REG_IMG_HEIGHT:  cfg_h    = val[9:0];
      REG_RADIUS_ROWS: cfg_rr   = val[5:0];
      REG_RADIUS_COLS: cfg_rc   = val[5:0];
      REG_CELL_STEP:   cfg_step = val[6:0];
      default: ;
    endcase
  endfunction

  function automatic void store_pixel(logic [47:0] d);
    bit free_px;
    free_px = d[7:0] == PIX_FULL && d[15:8] == PIX_FULL && d[23:16] == PIX_FULL;
    map_bits[ld_row * MAX_W + ld_col] = !free_px;
    advance_addr(ld_row, ld_col, clamp_dim(cfg_w, MAX_W), clamp_dim(cfg_h, MAX_H));
  endfunction

  function automatic cell_answer_t inflate_query(logic [8:0] gr, logic [8:0] gc);
    int unsigned  w, h, s, r0, c0, r1, c1, r, c;
    cell_answer_t ans;
    w = clamp_dim(cfg_w, MAX_W);
    h = clamp_dim(cfg_h, MAX_H);
    s = (cfg_step == 0) ? 1 : cfg_step;
    ans.row  = gr;
    ans.col  = gc;
    ans.inb  = gr < (h + s - 1) / s && gc < (w + s - 1) / s;
    ans.walk = 1'b0;
    if (ans.inb) begin
      r0 = gr * s;
      c0 = gc * s;
      r1 = r0 + ((cfg_rr > MAX_RAD) ? MAX_RAD : cfg_rr);
      c1 = c0 + ((cfg_rc > MAX_RAD) ? MAX_RAD : cfg_rc);
      if (r1 > h) r1 = h;
      if (c1 > w) c1 = w;
      ans.walk = 1'b1;
      for (r = r0; r < r1; r++)
        for (c = c0; c < c1; c++)
          if (map_bits[r * MAX_W + c]) ans.walk = 1'b0;
    end
    return ans;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus generation (tracks the load address so queries never hit unloaded pixels)

  int unsigned gen_row   = 0;
  int unsigned gen_col   = 0;
  int unsigned gen_w     = MAX_W;
  int unsigned gen_h     = MAX_H;
  int unsigned gen_step  = 1;
  int unsigned gen_items = 0;
  int unsigned n_phases  = 0;

  task automatic add_cfg(logic [2:0] idx, int unsigned val);
    req_item_t it;
    it.is_cfg  = 1'b1;
    it.reg_idx = idx;
    it.value   = val;
    it.kind    = REQ_LOAD;
    it.data    = '0;
    req_q.push_back(it);
    case (idx)
      REG_IMG_WIDTH:  gen_w    = clamp_dim(val & 10'h3FF, MAX_W);
      REG_IMG_HEIGHT: gen_h    = clamp_dim(val & 10'h3FF, MAX_H);
      REG_CELL_STEP:  gen_step = ((val & 7'h7F) == 0) ? 1 : (val & 7'h7F);
      default: ;
    endcase
  endtask

  task automatic add_load(logic [7:0] red, logic [7:0] green, logic [7:0] blue);
    req_item_t it;
    it.is_cfg  = 1'b0;
    it.reg_idx = '0;
    it.value   = '0;
    it.kind    = REQ_LOAD;
    // cell fields are don't-care on a load; randomize them
    it.data    = {6'd0, 9'($urandom), 9'($urandom), blue, green, red};
    req_q.push_back(it);
    advance_addr(gen_row, gen_col, gen_w, gen_h);
    gen_items++;
  endtask

  task automatic add_query(logic [8:0] gr, logic [8:0] gc);
    req_item_t it;
    it.is_cfg  = 1'b0;
    it.reg_idx = '0;
    it.value   = '0;
    it.kind    = REQ_QUERY;
    it.data    = {6'd0, gc, gr, 24'($urandom)};
    req_q.push_back(it);
    gen_items++;
  endtask

  task automatic add_pixel(int unsigned obst_pct);
    logic [7:0] ch;
    ch = 8'($urandom);
    if ($urandom_range(0, 99) < obst_pct) begin
      case ($urandom_range(0, 3))
        0: add_load(8'($urandom), 8'($urandom), 8'($urandom));
        1: add_load(8'd0, 8'd0, 8'd0);
        2: add_load(PIX_FULL, ch == PIX_FULL ? 8'd254 : ch, PIX_FULL);
        default: add_load(PIX_FULL, PIX_FULL, 8'd254);
      endcase
    end else begin
      add_load(PIX_FULL, PIX_FULL, PIX_FULL);
    end
  endtask

  task automatic realign(int unsigned obst_pct);
    while (gen_row != 0 || gen_col != 0) add_pixel(obst_pct);
  endtask

  task automatic add_phase(int unsigned w, int unsigned h, int unsigned rr, int unsigned rc,
                           int unsigned st, int unsigned obst_pct, int unsigned n_ops,
                           bit realign_after);
    int unsigned gh, gw;
    add_cfg(REG_IMG_WIDTH, w);
    add_cfg(REG_IMG_HEIGHT, h);
    add_cfg(REG_RADIUS_ROWS, rr);
    add_cfg(REG_RADIUS_COLS, rc);
    add_cfg(REG_CELL_STEP, st);
    realign(obst_pct);
    repeat (gen_w * gen_h) add_pixel(obst_pct);
    gh = (gen_h + gen_step - 1) / gen_step;
    gw = (gen_w + gen_step - 1) / gen_step;
    repeat (n_ops) begin
      if ($urandom_range(0, 99) < 20) add_pixel(obst_pct);
      else if ($urandom_range(0, 99) < 75)
        add_query(9'($urandom_range(0, gh - 1)), 9'($urandom_range(0, gw - 1)));
      else add_query(9'($urandom), 9'($urandom));
    end
    if (realign_after) realign(obst_pct);
    n_phases++;
  endtask

  function automatic int unsigned pick_radius();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return MAX_RAD;
      default: return $urandom_range(1, 6);
    endcase
  endfunction

  function automatic int unsigned pick_step();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 127;
      2: return 64;
      default: return $urandom_range(1, 4);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: bursts with random gaps, register writes only when the core is quiet

  int unsigned burst_left   = 1;
  int unsigned gap_left     = 0;
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    req_item_t nx;
    logic      nx_valid;
    logic      nx_psel;
    logic      nx_pen;
    if (rst_ni) begin
      nx_valid = s_axis_tvalid;
      nx_psel  = psel;
      nx_pen   = penable;
      if (s_axis_tvalid && s_axis_tready) begin
        nx_valid = 1'b0;
        if (s_axis_tuser == REQ_QUERY) queries_sent++;
      end
      if (psel && penable && pready) begin
        nx_psel = 1'b0;
        nx_pen  = 1'b0;
      end else if (psel) begin
        nx_pen = 1'b1;
      end
      if (!s_axis_tvalid && !psel && queries_sent == results_seen) quiet_cycles++;
      else quiet_cycles = 0;
      if (!nx_valid && !psel) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (req_q.size() > 0) begin
          if (req_q[0].is_cfg) begin
            if (quiet_cycles >= SETTLE) begin
              nx      = req_q.pop_front();
              paddr  <= {nx.reg_idx, 2'b00};
              pwdata <= nx.value;
              nx_psel = 1'b1;
              nx_pen  = 1'b0;
            end
          end else begin
            nx            = req_q.pop_front();
            s_axis_tdata <= nx.data;
            s_axis_tuser <= nx.kind;
            nx_valid      = 1'b1;
            if (burst_left > 1) begin
              burst_left--;
            end else if ($urandom_range(0, 3) == 0) begin
              burst_left = $urandom_range(40, 120);
              gap_left   = 0;
            end else begin
              burst_left = $urandom_range(1, 12);
              gap_left   = $urandom_range(0, 8);
            end
          end
        end
      end
      s_axis_tvalid <= nx_valid;
      psel          <= nx_psel;
      penable       <= nx_pen;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver backpressure: modes of always-ready, coin flip and long stalls

  int unsigned rx_mode  = 0;
  int unsigned rx_count = 0;

  always @(posedge clk_i) begin
    if (rx_count == 0) begin
      rx_mode  <= $urandom_range(0, 2);
      rx_count <= $urandom_range(20, 200);
    end else begin
      rx_count <= rx_count - 1;
    end
    case (rx_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= 1'($urandom_range(0, 1));
      default: m_axis_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Monitor and scoreboard

  task automatic check_field(string name, logic [8:0] want, logic [8:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    cell_answer_t got;
    cell_answer_t want;
    if (rst_ni) begin
      if (psel && penable && pwrite && pready) begin
        apply_reg(paddr[4:2], pwdata);
        n_cfg++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == REQ_LOAD) begin
          store_pixel(s_axis_tdata);
          n_loads++;
        end else begin
          cell_answers_q.push_back(inflate_query(s_axis_tdata[32:24], s_axis_tdata[41:33]));
          n_queries++;
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[8:0], m_axis_tdata[17:9], m_axis_tdata[18], m_axis_tdata[19]};
        if (cell_answers_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result transaction, expected none, actual %h",
                   $time, m_axis_tdata);
        end else begin
          want = cell_answers_q.pop_front();
          check_field("cell_row", want.row, got.row);
          check_field("cell_col", want.col, got.col);
          check_field("in_bounds", 9'(want.inb), 9'(got.inb));
          check_field("walkable", 9'(want.walk), 9'(got.walk));
          if (want.inb) n_inb++;
          if (want.walk) n_walk++;
        end
        results_seen <= results_seen + 1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, cell_answers_q.size());
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence

  initial begin
    int unsigned rand_start;
    int unsigned w, h;

    // directed: 4x3 image with every way a pixel can fail to be fully white
    add_cfg(REG_IMG_WIDTH, 4);
    add_cfg(REG_IMG_HEIGHT, 3);
    add_cfg(REG_RADIUS_ROWS, 2);
    add_cfg(REG_RADIUS_COLS, 2);
    add_cfg(REG_CELL_STEP, 1);
    add_load(8'd255, 8'd255, 8'd255);
    add_load(8'd0,   8'd0,   8'd0);
    add_load(8'd255, 8'd255, 8'd255);
    add_load(8'd255, 8'd255, 8'd255);
    add_load(8'd255, 8'd255, 8'd255);
    add_load(8'd255, 8'd255, 8'd255);
    add_load(8'd255, 8'd255, 8'd255);
    add_load(8'd254, 8'd255, 8'd255);
    add_load(8'd255, 8'd254, 8'd255);
    add_load(8'd255, 8'd255, 8'd255);
    add_load(8'd255, 8'd255, 8'd255);
    add_load(8'd255, 8'd255, 8'd254);
    add_query(9'd0, 9'd2);
    add_query(9'd1, 9'd1);
    add_query(9'd2, 9'd3);
    add_query(9'd3, 9'd0);
    add_query(9'd0, 9'd4);
    add_query(9'd511, 9'd511);
    // zero window height: always walkable
    add_cfg(REG_RADIUS_ROWS, 0);
    add_query(9'd0, 9'd0);
    add_cfg(REG_RADIUS_ROWS, MAX_RAD);
    add_cfg(REG_RADIUS_COLS, 0);
    add_query(9'd0, 9'd1);
    // zero step acts as one
    add_cfg(REG_RADIUS_COLS, MAX_RAD);
    add_cfg(REG_CELL_STEP, 0);
    add_query(9'd2, 9'd3);
    // one cell covers the whole image
    add_cfg(REG_CELL_STEP, 127);
    add_query(9'd0, 9'd0);
    add_query(9'd1, 9'd0);

    // extremes: widest single row, tallest single column
    rand_start = gen_items;
    add_phase(512, 0, MAX_RAD, MAX_RAD, 1, 3, 40, 1'b1);
    add_phase(0, 1023, MAX_RAD, 1, 64, 3, 30, 1'b1);
    while (gen_items - rand_start < RAND_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       w = 0;
        1:       w = $urandom_range(17, 40);
        default: w = $urandom_range(1, 16);
      endcase
      h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10);
      // skipping the final realign leaves the load address mid-image for the next size
      add_phase(w, h, pick_radius(), pick_radius(), pick_step(),
                ($urandom_range(0, 2) == 0) ? 30 : (($urandom_range(0, 1) == 0) ? 10 : 2),
                $urandom_range(20, 45), $urandom_range(0, 9) < 7);
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    while (req_q.size() != 0 || s_axis_tvalid || psel || queries_sent != results_seen)
      @(negedge clk_i);
    repeat (DRAIN) @(negedge clk_i);
    if (cell_answers_q.size() != 0) begin
      mismatches += cell_answers_q.size();
      $display("%0t: %0d expected results never arrived", $time, cell_answers_q.size());
    end
    $display("Covered %0d pixel loads and %0d cell queries (%0d in grid, %0d walkable)",
             n_loads, n_queries, n_inb, n_walk);
    $display("across %0d image setups and %0d register writes, %0d cycles",
             n_phases + 1, n_cfg, cycle_count);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### obstacle_inflation_grid_map_core.f
rtl/oigm_pkg.sv
rtl/oigm_map.sv
rtl/obstacle_inflation_grid_map_core.sv
tb/tb_obstacle_inflation_grid_map_core.sv
